// File: design/pairwise_total_accumulator_top_defines.svh
// Assertion helpers shared by the accumulator modules.
`ifndef PAIRWISE_TOTAL_ACCUMULATOR_TOP_DEFINES_SVH
`define PAIRWISE_TOTAL_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pairwise total accumulator: implication failed");

// Next-cycle implication, disabled during reset.
`define PTA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pairwise total accumulator: next-cycle check failed");

`endif

// File: design/pta_pkg.sv
package pta_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int TOTAL_BITS  = 24;

  // Fixed field widths
  localparam int ID_W       = 8;
  localparam int AMOUNT_W   = 24;
  localparam int OUT_W      = 24;
  localparam int SC_W       = 9;
  localparam int THR_W      = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int STORE_DEPTH = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int N_W         = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W       = (N_W > SC_W) ? N_W : SC_W;
  localparam int PROD_W      = N_W + 1 + ID_W;

  localparam logic [SC_W-1:0]  SAMPLE_COUNT_RST     = SC_W'(256);
  localparam logic [THR_W-1:0] REPORT_THRESHOLD_RST = THR_W'(486);

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_THRESHOLD = CFG_IDX_W'(1);

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAME  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic calc_load;
    logic mem_rd;
    logic out_load;
  } pta_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic item_err;
    logic out_free;
  } pta_stat_t;

endpackage

// File: design/pta_in_if.sv
interface pta_in_if import pta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [ID_W-1:0]     first_id;
  logic [ID_W-1:0]     second_id;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, action, first_id, second_id, amount, input ready);
  modport sink   (input valid, action, first_id, second_id, amount, output ready);
endinterface

// File: design/pta_out_if.sv
interface pta_out_if import pta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] total;
  logic             above_threshold;
  logic             saturated;
  logic [1:0]       status;

  modport source (output valid, total, above_threshold, saturated, status, input ready);
  modport sink   (input valid, total, above_threshold, saturated, status, output ready);
endinterface

// File: design/pta_cfg_if.sv
interface pta_cfg_if import pta_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/pta_ctrl.sv
`include "pairwise_total_accumulator_top_defines.svh"

module pta_ctrl import pta_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pta_stat_t stat,
  output pta_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_INDEX;
      end
      S_INDEX: begin
        // skip the store for a bad pair
        state_next = stat.item_err ? S_UPDATE : S_READ;
      end
      S_READ: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_INDEX: begin
        cmd.calc_load = 1'b1;
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
      end
      S_UPDATE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PTA_ASSERT_IMP(a_out_load_free, clk, rst, cmd.out_load, stat.out_free)
  `PTA_ASSERT_NEXT(a_load_to_index, clk, rst, cmd.load_item, state == S_INDEX)
  `PTA_ASSERT_IMP(a_no_read_on_err, clk, rst, cmd.calc_load && stat.item_err, state_next == S_UPDATE)

endmodule

// File: design/pta_datapath.sv
`include "pairwise_total_accumulator_top_defines.svh"

module pta_datapath import pta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  pta_cmd_t              cmd,
  output pta_stat_t             stat,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // item payload
  input  logic                  in_action,
  input  logic [ID_W-1:0]       in_first_id,
  input  logic [ID_W-1:0]       in_second_id,
  input  logic [AMOUNT_W-1:0]   in_amount,
  // result register
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_total,
  output logic                  out_above,
  output logic                  out_sat,
  output status_t               out_status
);

  logic [SC_W-1:0]       sample_count;
  logic [THR_W-1:0]      report_threshold;

  logic                  it_action;
  logic [ID_W-1:0]       it_lo;
  logic [ID_W-1:0]       it_hi;
  logic [AMOUNT_W-1:0]   it_amount;
  status_t               it_status;

  logic [ADDR_W-1:0]     idx;
  logic [ADDR_W-1:0]     clr_addr;
  logic [TOTAL_BITS-1:0] rd_data;
  logic [TOTAL_BITS-1:0] mem [STORE_DEPTH];

  logic [N_W-1:0]        n_eff;
  status_t               chk_status;
  logic [PROD_W-1:0]     row_span;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     idx_full;
  logic [ADDR_W-1:0]     idx_calc;

  logic [TOTAL_BITS:0]   sum;
  logic [TOTAL_BITS-1:0] new_total;
  logic [TOTAL_BITS-1:0] res_total;
  logic                  res_sat;
  logic                  res_above;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [TOTAL_BITS-1:0] mem_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= SAMPLE_COUNT_RST;
      report_threshold <= REPORT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT:     sample_count     <= cfg_data[SC_W-1:0];
        CFG_REPORT_THRESHOLD: report_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp n to the store's sample limit
  always_comb begin
    if (CMP_W'(sample_count) > CMP_W'(MAX_SAMPLES)) begin
      n_eff = N_W'(MAX_SAMPLES);
    end else begin
      n_eff = N_W'(sample_count);
    end
  end

  always_comb begin
    if (in_first_id == in_second_id) begin
      chk_status = ST_SAME;
    end else if (CMP_W'(in_first_id) >= CMP_W'(n_eff) ||
                 CMP_W'(in_second_id) >= CMP_W'(n_eff)) begin
      chk_status = ST_RANGE;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_action <= in_action;
      it_amount <= in_amount;
      it_status <= chk_status;
      if (in_first_id < in_second_id) begin
        it_lo <= in_first_id;
        it_hi <= in_second_id;
      end else begin
        it_lo <= in_second_id;
        it_hi <= in_first_id;
      end
    end
  end

  // packed index (2n-a-1)*a/2 + b-a-1; the product is always even
  always_comb begin
    row_span = PROD_W'({n_eff, 1'b0}) - PROD_W'(it_lo) - PROD_W'(1);
    prod     = row_span * PROD_W'(it_lo);
    idx_full = (prod >> 1) + PROD_W'(it_hi) - PROD_W'(it_lo) - PROD_W'(1);
    idx_calc = idx_full[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_load) begin
      idx <= idx_calc;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    sum       = {1'b0, rd_data} + (TOTAL_BITS + 1)'(it_amount);
    new_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
    res_sat   = 1'b0;
    res_total = '0;
    if (it_status == ST_OK) begin
      if (it_action == ACT_ADD) begin
        res_total = new_total;
        res_sat   = sum[TOTAL_BITS];
      end else begin
        res_total = rd_data;
      end
    end
    res_above = (it_status == ST_OK) &&
                ((TOTAL_BITS + THR_W)'(res_total) >= (TOTAL_BITS + THR_W)'(report_threshold));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = new_total;
    if (cmd.clear_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (cmd.out_load && it_status == ST_OK && it_action == ACT_ADD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data <= mem[idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total  <= res_total[OUT_W-1:0];
      out_above  <= res_above;
      out_sat    <= res_sat;
      out_status <= it_status;
    end
  end

  always_comb begin
    stat.clear_last = (clr_addr == ADDR_W'(STORE_DEPTH - 1));
    stat.item_err   = (it_status != ST_OK);
    stat.out_free   = !out_valid || out_ready;
  end

  `PTA_ASSERT_IMP(a_idx_in_store, clk, rst, cmd.mem_rd, 32'(idx) < 32'(STORE_DEPTH))
  `PTA_ASSERT_IMP(a_err_zero, clk, rst, out_valid && out_status != ST_OK, out_total == '0 && !out_above && !out_sat)
  `PTA_ASSERT_IMP(a_sat_full, clk, rst, out_valid && out_sat, out_total == '1 && out_status == ST_OK)

endmodule

// File: design/pairwise_total_accumulator_top.sv
// Channel   Role    Payload
// item      sink    action, first_id, second_id, amount
// result    source  total, above_threshold, saturated, status
// cfg       sink    index, data (0: sample_count, 1: report_threshold)
//
// One item at a time: accept, index multiply, store read, update/writeback;
// a rejected pair skips the store read and goes straight to update/writeback.
// After rst the store is cleared one entry per cycle, all 32640 entries, and
// item.ready stays low meanwhile; cfg writes are taken at any time.
// A waiting result does not block the next accept; a stalled result holds
// the following item in its update step.
module pairwise_total_accumulator_top import pta_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pta_in_if.sink   item,
  pta_out_if.source result,
  pta_cfg_if.sink  cfg
);

  pta_cmd_t  cmd;
  pta_stat_t stat;
  status_t   out_status;

  assign cfg.ready = 1'b1;

  pta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pta_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .in_action    (item.action),
    .in_first_id  (item.first_id),
    .in_second_id (item.second_id),
    .in_amount    (item.amount),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_total    (result.total),
    .out_above    (result.above_threshold),
    .out_sat      (result.saturated),
    .out_status   (out_status)
  );

  assign result.status = out_status;

endmodule
